### rtl/text_glyph_framebuffer_writer_defines.svh
`ifndef TEXT_GLYPH_FRAMEBUFFER_WRITER_DEFINES_SVH
`define TEXT_GLYPH_FRAMEBUFFER_WRITER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TGFW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgfw same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TGFW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgfw next-cycle check failed");

`endif

### rtl/tgfw_pkg.sv
package tgfw_pkg;

   localparam int COL_W       = 7;
   localparam int PAGE_W      = 4;
   localparam int ADDR_W      = 10;
   localparam int BYTE_W      = 8;
   localparam int CHAR_W      = 8;
   localparam int GLYPH_IDX_W = 7;
   localparam int GLYPH_WIDTH = 5;
   localparam int BEAT_W      = 3;
   localparam int ROW_W       = GLYPH_WIDTH * BYTE_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST    = 8'h7E;

   typedef logic [BEAT_W-1:0] beat_type;

   // one glyph to draw: first framebuffer address and font index
   typedef struct packed {
      logic [ADDR_W-1:0]      base_addr;
      logic [GLYPH_IDX_W-1:0] glyph_index;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // font row, leftmost column in the top byte
   function automatic logic [ROW_W-1:0] font_row(input logic [GLYPH_IDX_W-1:0] idx);
      logic [ROW_W-1:0] row;
      case (idx)
         7'd0  : row = 40'h00_00_00_00_00;
         7'd1  : row = 40'h00_00_2F_00_00;
         7'd2  : row = 40'h00_07_00_07_00;
         7'd3  : row = 40'h14_7F_14_7F_14;
         7'd4  : row = 40'h24_2A_7F_2A_12;
         7'd5  : row = 40'h23_13_08_64_62;
         7'd6  : row = 40'h36_49_55_22_50;
         7'd7  : row = 40'h00_05_03_00_00;
         7'd8  : row = 40'h00_1C_22_41_00;
         7'd9  : row = 40'h00_41_22_1C_00;
         7'd10 : row = 40'h14_08_3E_08_14;
         7'd11 : row = 40'h08_08_3E_08_08;
         7'd12 : row = 40'h00_00_A0_60_00;
         7'd13 : row = 40'h08_08_08_08_08;
         7'd14 : row = 40'h00_60_60_00_00;
         7'd15 : row = 40'h20_10_08_04_02;
         7'd16 : row = 40'h3E_51_49_45_3E;
         7'd17 : row = 40'h00_42_7F_40_00;
         7'd18 : row = 40'h42_61_51_49_46;
         7'd19 : row = 40'h21_41_45_4B_31;
         7'd20 : row = 40'h18_14_12_7F_10;
         7'd21 : row = 40'h27_45_45_45_39;
         7'd22 : row = 40'h3C_4A_49_49_30;
         7'd23 : row = 40'h01_71_09_05_03;
         7'd24 : row = 40'h36_49_49_49_36;
         7'd25 : row = 40'h06_49_49_29_1E;
         7'd26 : row = 40'h00_36_36_00_00;
         7'd27 : row = 40'h00_56_36_00_00;
         7'd28 : row = 40'h08_14_22_41_00;
         7'd29 : row = 40'h14_14_14_14_14;
         7'd30 : row = 40'h00_41_22_14_08;
         7'd31 : row = 40'h02_01_51_09_06;
         7'd32 : row = 40'h32_49_59_51_3E;
         7'd33 : row = 40'h7C_12_11_12_7C;
         7'd34 : row = 40'h7F_49_49_49_36;
         7'd35 : row = 40'h3E_41_41_41_22;
         7'd36 : row = 40'h7F_41_41_22_1C;
         7'd37 : row = 40'h7F_49_49_49_41;
         7'd38 : row = 40'h7F_09_09_09_01;
         7'd39 : row = 40'h3E_41_49_49_7A;
         7'd40 : row = 40'h7F_08_08_08_7F;
         7'd41 : row = 40'h00_41_7F_41_00;
         7'd42 : row = 40'h20_40_41_3F_01;
         7'd43 : row = 40'h7F_08_14_22_41;
         7'd44 : row = 40'h7F_40_40_40_40;
         7'd45 : row = 40'h7F_02_0C_02_7F;
         7'd46 : row = 40'h7F_04_08_10_7F;
         7'd47 : row = 40'h3E_41_41_41_3E;
         7'd48 : row = 40'h7F_09_09_09_06;
         7'd49 : row = 40'h3E_41_51_21_5E;
         7'd50 : row = 40'h7F_09_19_29_46;
         7'd51 : row = 40'h46_49_49_49_31;
         7'd52 : row = 40'h01_01_7F_01_01;
         7'd53 : row = 40'h3F_40_40_40_3F;
         7'd54 : row = 40'h1F_20_40_20_1F;
         7'd55 : row = 40'h3F_40_38_40_3F;
         7'd56 : row = 40'h63_14_08_14_63;
         7'd57 : row = 40'h07_08_70_08_07;
         7'd58 : row = 40'h61_51_49_45_43;
         7'd59 : row = 40'h00_7F_41_41_00;
         7'd60 : row = 40'h55_AA_55_AA_55;
         7'd61 : row = 40'h00_41_41_7F_00;
         7'd62 : row = 40'h04_02_01_02_04;
         7'd63 : row = 40'h40_40_40_40_40;
         7'd64 : row = 40'h00_03_05_00_00;
         7'd65 : row = 40'h20_54_54_54_78;
         7'd66 : row = 40'h7F_48_44_44_38;
         7'd67 : row = 40'h38_44_44_44_20;
         7'd68 : row = 40'h38_44_44_48_7F;
         7'd69 : row = 40'h38_54_54_54_18;
         7'd70 : row = 40'h08_7E_09_01_02;
         7'd71 : row = 40'h18_A4_A4_A4_7C;
         7'd72 : row = 40'h7F_08_04_04_78;
         7'd73 : row = 40'h00_44_7D_40_00;
         7'd74 : row = 40'h40_80_84_7D_00;
         7'd75 : row = 40'h7F_10_28_44_00;
         7'd76 : row = 40'h00_41_7F_40_00;
         7'd77 : row = 40'h7C_04_18_04_78;
         7'd78 : row = 40'h7C_08_04_04_78;
         7'd79 : row = 40'h38_44_44_44_38;
         7'd80 : row = 40'hFC_24_24_24_18;
         7'd81 : row = 40'h18_24_24_18_FC;
         7'd82 : row = 40'h7C_08_04_04_08;
         7'd83 : row = 40'h48_54_54_54_20;
         7'd84 : row = 40'h04_3F_44_40_20;
         7'd85 : row = 40'h3C_40_40_20_7C;
         7'd86 : row = 40'h1C_20_40_20_1C;
         7'd87 : row = 40'h3C_40_30_40_3C;
         7'd88 : row = 40'h44_28_10_28_44;
         7'd89 : row = 40'h1C_A0_A0_A0_7C;
         7'd90 : row = 40'h44_64_54_4C_44;
         7'd91 : row = 40'h00_10_7C_82_00;
         7'd92 : row = 40'h00_00_FF_00_00;
         7'd93 : row = 40'h00_82_7C_10_00;
         7'd94 : row = 40'h00_06_09_09_06;
         default : row = '0;
      endcase
      return row;
   endfunction

   // one column byte of a glyph
   function automatic logic [BYTE_W-1:0] font_column(input logic [GLYPH_IDX_W-1:0] idx,
                                                     input beat_type beat);
      logic [ROW_W-1:0]  row;
      logic [BYTE_W-1:0] col;
      row = font_row(idx);
      case (beat)
         3'd0    : col = row[39:32];
         3'd1    : col = row[31:24];
         3'd2    : col = row[23:16];
         3'd3    : col = row[15:8];
         3'd4    : col = row[7:0];
         default : col = '0;
      endcase
      return col;
   endfunction

endpackage

### rtl/tgfw_front.sv
module tgfw_front #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int PAGE_COUNT     = 8,
   parameter int GLYPH_PITCH    = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                char_code,
   input  logic                      end_of_text,
   input  tgfw_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output tgfw_pkg::cmd_type         push_cmd
);
   import tgfw_pkg::*;

   localparam int WRAP_COLUMN = SCREEN_COLUMNS - GLYPH_PITCH;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;

   logic              accept;
   logic              wrap;
   logic [COL_W-1:0]  col_wrapped;
   logic [PAGE_W-1:0] page_wrapped;
   logic              printable;
   logic              draw;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      // wrap on newline or when the column reaches SCREEN_COLUMNS - GLYPH_PITCH
      wrap = (char_code == CHAR_NEWLINE) ||
             ({2'b00, col_ff} >= 9'(WRAP_COLUMN));
      col_wrapped  = wrap ? '0 : col_ff;
      page_wrapped = page_ff;
      if (wrap && (page_ff < PAGE_W'(PAGE_COUNT))) begin
         page_wrapped = page_ff + 4'd1;
      end
      // leading space on a line is skipped
      printable = (char_code >= CHAR_SPACE) && (char_code <= CHAR_LAST) &&
                  !((col_wrapped == '0) && (char_code == CHAR_SPACE));
      draw = printable && (page_wrapped < PAGE_W'(PAGE_COUNT));

      push_cmd.base_addr   = ADDR_W'(col_wrapped) + ADDR_W'(page_wrapped * SCREEN_COLUMNS);
      push_cmd.glyph_index = GLYPH_IDX_W'(char_code - CHAR_SPACE);
      push_valid           = accept && draw;

      col_in  = col_ff;
      page_in = page_ff;
      if (accept) begin
         col_in  = printable ? COL_W'(col_wrapped + COL_W'(GLYPH_PITCH)) : col_wrapped;
         page_in = page_wrapped;
         if (end_of_text) begin
            col_in  = '0;
            page_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         page_ff <= '0;
      end else begin
         col_ff  <= col_in;
         page_ff <= page_in;
      end
   end

endmodule

### rtl/tgfw_cmd_queue.sv
module tgfw_cmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  tgfw_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output tgfw_pkg::cmd_type          head_cmd,
   output tgfw_pkg::queue_status_type queue_status
);
   import tgfw_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign queue_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_cmd           = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/tgfw_back.sv
`include "text_glyph_framebuffer_writer_defines.svh"

module tgfw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tgfw_pkg::cmd_type          head_cmd,
   input  tgfw_pkg::queue_status_type queue_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [9:0]                 write_address,
   output logic [7:0]                 write_byte,
   output logic                       last_of_run
);
   import tgfw_pkg::*;

   beat_type          beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              load;

   // next column goes out when the head is valid and the output slot frees up
   assign load = !queue_status.empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_addr_in  = head_cmd.base_addr + ADDR_W'(beat_ff);
      rsp_byte_in  = font_column(head_cmd.glyph_index, beat_ff);
      rsp_last_in  = (beat_ff == BEAT_W'(GLYPH_WIDTH - 1));
      pop          = load && rsp_last_in;
      beat_in      = beat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load) begin
         beat_in      = rsp_last_in ? '0 : beat_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_addr_ff <= rsp_addr_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign write_address = rsp_addr_ff;
   assign write_byte    = rsp_byte_ff;
   assign last_of_run   = rsp_last_ff;

   `TGFW_ASSERT_SAME(a_beat_range, clock, reset, 1'b1, beat_ff < BEAT_W'(GLYPH_WIDTH))
   `TGFW_ASSERT_SAME(a_mid_glyph_holds_cmd, clock, reset, beat_ff != '0, !queue_status.empty)
   `TGFW_ASSERT_SAME(a_addr_steps, clock, reset, load && rsp_valid_ff && !rsp_last_ff, rsp_addr_in == rsp_addr_ff + 10'd1)
   `TGFW_ASSERT_NEXT(a_last_restarts_beat, clock, reset, load && rsp_last_in, beat_ff == '0)

endmodule

### rtl/text_glyph_framebuffer_writer.sv
// the first column write comes from the output register in tgfw_back, fed from the glyph queue
// a drawn character gives five framebuffer writes, one per cycle while rsp_tready is high,
//   on the single result port; other characters write nothing
// a two-entry glyph queue lets new requests be taken while earlier glyphs drain
// reset (synchronous, active high) puts the cursor at page 0, column 0 and empties the queue
module text_glyph_framebuffer_writer #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int PAGE_COUNT     = 8,
   parameter int GLYPH_PITCH    = 6
) (
   input  logic        clock,
   input  logic        reset,
   // character requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   // framebuffer writes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] write_address, [17:10] write_byte, [23:18] zero
   output logic        rsp_tlast    // last_of_run
);
   import tgfw_pkg::*;

   // front to queue
   logic             push_valid;
   cmd_type          push_cmd;
   // queue to back
   cmd_type          head_cmd;
   queue_status_type queue_status;
   logic             pop;
   // result payload
   logic [ADDR_W-1:0] write_address;
   logic [BYTE_W-1:0] write_byte;

   // front: cursor tracking, wrap and skip rules, glyph command build
   tgfw_front #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .PAGE_COUNT     (PAGE_COUNT),
      .GLYPH_PITCH    (GLYPH_PITCH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .char_code    (req_tdata),
      .end_of_text  (req_tlast),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd)
   );

   // glyph commands waiting for the writer
   tgfw_cmd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd),
      .pop          (pop),
      .head_cmd     (head_cmd),
      .queue_status (queue_status)
   );

   // back: steps through the five font columns into the output register
   tgfw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .queue_status  (queue_status),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .write_address (write_address),
      .write_byte    (write_byte),
      .last_of_run   (rsp_tlast)
   );

   // pack payload, lowest field first
   assign rsp_tdata = {6'b000000, write_byte, write_address};

endmodule
